// ----- design/upd_pkg.sv -----
// upd_pkg: shared types and constants of the uri percent decoder
// no dependencies; imported by the request and response interfaces, the decode engine, the top level and the checker
package upd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 2;

   localparam logic [STATUS_W-1:0] ST_CONT    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

   localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
   localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CH_QUEST   = 8'h3f;
   localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CASE_MASK  = 8'hdf;
   localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
   localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                out_valid;
      logic [STATUS_W-1:0] status;
      logic                in_query;
   } upd_result_type;

endpackage

// ----- design/upd_if.sv -----
// upd_if: valid/ready channel interfaces for request, response and csr write
// depends on upd_pkg
interface upd_req_if import upd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface upd_rsp_if import upd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                out_valid;
   logic [STATUS_W-1:0] status;
   logic                in_query;

   modport source (output valid, output out_byte, output out_valid, output status,
                   output in_query, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input status,
                   input in_query, output ready);
endinterface

interface upd_csr_if ();
   logic valid;
   logic ready;
   logic query_wanted;

   modport source (output valid, output query_wanted, input ready);
   modport sink   (input valid, input query_wanted, output ready);
endinterface

// ----- design/upd_engine.sv -----
// upd_engine: decode mode register and per-byte percent decode logic
// depends on upd_pkg; result is combinational from the held mode and the current byte
module upd_engine import upd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [BYTE_W-1:0] cur_byte,
   input  logic              query_wanted,
   output upd_result_type    result
);

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_HEX1   = 3'd1,
      MODE_HEX2   = 3'd2,
      MODE_SCAN   = 3'd3,
      MODE_DONE   = 3'd4
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [BYTE_W-1:0] first_hex_ff, first_hex_in;
   logic              query_active_ff, query_active_in;

   logic [BYTE_W-1:0] hex_hi;
   logic [BYTE_W-1:0] hex_lo;
   logic [BYTE_W-1:0] decoded;
   logic              decoded_bad;

   function automatic logic [BYTE_W-1:0] loose_hex(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      if (b >= CH_UPPER_A) begin
         r = (b & CASE_MASK) - CH_UPPER_A + BYTE_W'(10);
      end else begin
         r = b - CH_ZERO;
      end
      return r;
   endfunction

   assign hex_hi      = loose_hex(first_hex_ff);
   assign hex_lo      = loose_hex(cur_byte);
   assign decoded     = {hex_hi[3:0], 4'b0000} + hex_lo;
   assign decoded_bad = (decoded < PRINT_LO) || (decoded > PRINT_HI);

   always_comb begin
      mode_in         = mode_ff;
      first_hex_in    = first_hex_ff;
      query_active_in = query_active_ff;
      result          = '{out_byte: CH_NUL, out_valid: 1'b0, status: ST_CONT, in_query: 1'b0};
      unique case (mode_ff)
         MODE_HEX1: begin
            if (cur_byte == CH_NUL) begin
               result.status   = ST_ILLEGAL;
               mode_in         = MODE_NORMAL;
               first_hex_in    = CH_NUL;
               query_active_in = 1'b0;
            end else begin
               first_hex_in = cur_byte;
               mode_in      = MODE_HEX2;
            end
         end
         MODE_HEX2: begin
            first_hex_in = CH_NUL;
            if (cur_byte == CH_NUL) begin
               result.status   = ST_ILLEGAL;
               mode_in         = MODE_NORMAL;
               query_active_in = 1'b0;
            end else if (decoded_bad) begin
               result.status   = ST_ILLEGAL;
               mode_in         = MODE_DONE;
               query_active_in = 1'b0;
            end else begin
               result.out_byte  = decoded;
               result.out_valid = 1'b1;
               mode_in          = MODE_NORMAL;
            end
         end
         MODE_SCAN: begin
            result.status = ST_IGNORED;
            if (cur_byte == CH_NUL) begin
               mode_in         = MODE_NORMAL;
               first_hex_in    = CH_NUL;
               query_active_in = 1'b0;
            end else if (cur_byte == CH_QUEST) begin
               mode_in         = MODE_DONE;
               query_active_in = 1'b1;
            end
         end
         MODE_DONE: begin
            result.status = ST_IGNORED;
            if (cur_byte == CH_NUL) begin
               mode_in         = MODE_NORMAL;
               first_hex_in    = CH_NUL;
               query_active_in = 1'b0;
            end else begin
               result.in_query = query_active_ff;
            end
         end
         default: begin
            priority if (cur_byte == CH_NUL) begin
               result.status   = ST_OK;
               mode_in         = MODE_NORMAL;
               first_hex_in    = CH_NUL;
               query_active_in = 1'b0;
            end else if (cur_byte == CH_PERCENT) begin
               mode_in = MODE_HEX1;
            end else if (cur_byte == CH_QUEST) begin
               result.status   = ST_OK;
               mode_in         = MODE_DONE;
               query_active_in = query_wanted;
            end else if (cur_byte == CH_HASH) begin
               result.status   = ST_OK;
               mode_in         = query_wanted ? MODE_SCAN : MODE_DONE;
               query_active_in = 1'b0;
            end else begin
               result.out_byte  = cur_byte;
               result.out_valid = 1'b1;
               mode_in          = MODE_NORMAL;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_NORMAL;
         first_hex_ff    <= CH_NUL;
         query_active_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff         <= mode_in;
         first_hex_ff    <= first_hex_in;
         query_active_ff <= query_active_in;
      end
   end

endmodule

// ----- design/uri_percent_decoder.sv -----
// uri_percent_decoder: top level, request register, decode engine and response register
// depends on upd_pkg, upd_if and upd_engine
//
//  channel  | dir | payload                               | handshake
//  req_if   | in  | in_byte[7:0]                          | valid / ready
//  rsp_if   | out | out_byte[7:0] out_valid status in_query | valid / ready
//  csr_if   | in  | query_wanted                          | valid / ready (always ready)
//
// one request per cycle while rsp_if is ready; request and response are each registered
// the decode mode register updates as a request moves from the request register to the response
// reset is synchronous: mode returns to normal copy, query_wanted to 1, both stages empty
// a stalled response holds; the request register then fills and req_if.ready drops
module uri_percent_decoder import upd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   upd_req_if.sink  req_if,
   upd_rsp_if.source rsp_if,
   upd_csr_if.sink  csr_if
);

   logic              req_valid_ff;
   logic [BYTE_W-1:0] req_byte_ff;
   logic              rsp_valid_ff;
   upd_result_type    rsp_data_ff;
   logic              query_wanted_ff;

   logic              advance;
   upd_result_type    step_result;

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   upd_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .cur_byte     (req_byte_ff),
      .query_wanted (query_wanted_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         query_wanted_ff <= 1'b1;
      end else if (csr_if.valid) begin
         query_wanted_ff <= csr_if.query_wanted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         req_byte_ff <= req_if.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_if.ready) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_byte  = rsp_data_ff.out_byte;
   assign rsp_if.out_valid = rsp_data_ff.out_valid;
   assign rsp_if.status    = rsp_data_ff.status;
   assign rsp_if.in_query  = rsp_data_ff.in_query;

endmodule

// ----- design/upd_checker.sv -----
// upd_checker: port-level assertions on the decoder response channel, with its bind
// depends on upd_pkg; attached to uri_percent_decoder
module upd_checker import upd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BYTE_W-1:0]   rsp_out_byte,
   input logic                rsp_out_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_in_query
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_char_is_continuing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == ST_CONT && rsp_out_byte != CH_NUL
         && !rsp_in_query)
      else $error("decoded character with wrong status or null byte");

   a_query_is_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_query |-> rsp_status == ST_IGNORED && !rsp_out_valid)
      else $error("query byte not flagged as ignored");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_valid) && $stable(rsp_status) && $stable(rsp_in_query))
      else $error("stalled response changed");

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_out_byte  (rsp_if.out_byte),
   .rsp_out_valid (rsp_if.out_valid),
   .rsp_status    (rsp_if.status),
   .rsp_in_query  (rsp_if.in_query)
);
